// ===== rtl/core/dfcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcs_pkg
// Types and constants shared by the DAC frequency calibration sweep unit.
// ----------------------------------------------------------------------------
package dfcs_pkg;

  // DAC resolution; the top code of a sweep is all ones at this width
  localparam int DAC_BITS = 12;

  localparam int OP_W      = 2;
  localparam int FREQ_W    = 32;
  localparam int KIND_W    = 2;
  localparam int DAC_OUT_W = 12;
  localparam int TCODE_W   = 14;
  localparam int LIMIT_W   = 4;
  localparam int TOL_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;
  localparam int PROD_W    = FREQ_W + TOL_W;

  localparam logic [LIMIT_W-1:0] READ_LIMIT_RST = LIMIT_W'(10);
  localparam logic [TOL_W-1:0]   TOL_DIV_RST    = TOL_W'(100);
  localparam logic [LIMIT_W-1:0] COUNT_MAX      = '1;
  localparam logic [TCODE_W-1:0] HALF_OFFSET    = TCODE_W'(16'h2000);
  localparam logic [DAC_BITS-1:0] CODE_TOP      = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ABORT   = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] K_RESET = 2'd0;
  localparam logic [KIND_W-1:0] K_SET   = 2'd1;
  localparam logic [KIND_W-1:0] K_SAVE  = 2'd2;
  localparam logic [KIND_W-1:0] K_DONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_DIV    = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic              half_mode;
    logic [FREQ_W-1:0] frequency;
  } dfcs_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [DAC_OUT_W-1:0] dac_code;
    logic                 half_range;
    logic [TCODE_W-1:0]   table_code;
    logic [FREQ_W-1:0]    saved_frequency;
    logic                 aborted;
    logic                 last;
  } dfcs_out_t;

  // up to two results written into the result queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    dfcs_out_t  first;
    dfcs_out_t  second;
  } dfcs_push_t;

endpackage

// ===== rtl/core/dac_frequency_calibration_sweep_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_frequency_calibration_sweep_unit
// Steps a DAC code from zero to full scale while checking oscillator readings
// for stability, and emits table reset, set code, save and finished commands.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------
//  in       | input     | in_valid / in_ready       | in_item  (dfcs_in_t)
//  out      | output    | out_valid / out_ready     | out_item (dfcs_out_t)
//  cfg      | input     | cfg_write, no back-pressure | cfg_index, cfg_data
//
// An accepted item is registered in the input register and evaluated
// combinationally (subtract, 10-bit by 32-bit multiply, compare) once the
// queue has room for two results; its results, up to two, are then written
// into a four-entry queue whose head drives the output. One item can be
// taken every cycle while the queue has room; the sustained rate is bounded
// by the output port, one result a cycle, so items with two results hold back the input.
// Reset restores read_limit 10 and tolerance_divisor 100 and leaves the
// sweep idle. A stalled output fills the queue, then holds the input register.
// ----------------------------------------------------------------------------
module dac_frequency_calibration_sweep_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dfcs_pkg::dfcs_in_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dfcs_pkg::dfcs_out_t            out_item,
  input  logic                           cfg_write,
  input  logic [dfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfcs_pkg::CFG_W-1:0]     cfg_data
);
  import dfcs_pkg::*;

  // input register
  logic       held_valid;
  dfcs_in_t   held_item;
  logic       room;
  logic       fire;
  dfcs_push_t push;

  // evaluate the held item once the queue has space for both results
  assign fire     = held_valid && room;
  // take a new item whenever the register is empty or draining this cycle
  assign in_ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload needs no reset; advance only on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

  dfcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (held_item),
    .push      (push)
  );

  dfcs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/dfcs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcs_core
// Sweep state, configuration registers and the per-item decision logic.
// ----------------------------------------------------------------------------
module dfcs_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfcs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           fire,
  input  dfcs_pkg::dfcs_in_t             item,
  output dfcs_pkg::dfcs_push_t           push
);
  import dfcs_pkg::*;

  logic [LIMIT_W-1:0]  read_limit;
  logic [TOL_W-1:0]    tol_div;
  logic                busy, busy_next;
  logic [DAC_BITS-1:0] code, code_next;
  logic [FREQ_W-1:0]   prev_freq, prev_freq_next;
  logic [LIMIT_W-1:0]  count, count_next;
  logic                half, half_next;

  logic [LIMIT_W:0]    count_inc;
  logic [FREQ_W-1:0]   diff;
  logic [PROD_W-1:0]   prod;
  logic                stable;
  logic                save;
  logic [DAC_BITS-1:0] code_inc;
  logic [TCODE_W-1:0]  tcode;
  dfcs_out_t           blank;

  assign count_inc = {1'b0, count} + 1'b1;
  assign diff      = (item.frequency >= prev_freq) ? item.frequency - prev_freq
                                                   : prev_freq - item.frequency;
  assign prod      = PROD_W'(diff) * PROD_W'(tol_div);
  assign stable    = prod <= PROD_W'(item.frequency);
  assign code_inc  = code + 1'b1;
  assign tcode     = TCODE_W'(code) + (half ? HALF_OFFSET : '0);
  assign blank     = '0;

  always_comb begin
    busy_next      = busy;
    code_next      = code;
    prev_freq_next = prev_freq;
    count_next     = count;
    half_next      = half;
    save           = 1'b0;
    push           = '0;
    push.first     = blank;
    push.second    = blank;

    unique case (item.operation)
      OP_START: begin
        if (!busy) begin
          busy_next                = 1'b1;
          half_next                = item.half_mode;
          code_next                = '0;
          prev_freq_next           = '0;
          count_next               = '0;
          push.count               = 2'd2;
          push.first.kind          = K_RESET;
          push.second.kind         = K_SET;
          push.second.half_range   = item.half_mode;
          push.second.last         = 1'b1;
        end
      end
      OP_ABORT: begin
        if (busy) begin
          busy_next             = 1'b0;
          push.count            = 2'd1;
          push.first.kind       = K_DONE;
          push.first.aborted    = 1'b1;
          push.first.last       = 1'b1;
        end
      end
      OP_MEASURE: begin
        if (busy) begin
          if (count == '0) begin
            // first reading for this code only primes
            prev_freq_next = item.frequency;
            count_next     = LIMIT_W'(1);
          end else begin
            count_next = count_inc[LIMIT_W] ? COUNT_MAX : count_inc[LIMIT_W-1:0];
            priority if (count_inc > {1'b0, read_limit}) begin
              save = 1'b1;
            end else if (item.frequency != '0 && prev_freq == '0) begin
              prev_freq_next = item.frequency;
            end else if (item.frequency == '0) begin
              save = 1'b1;
            end else begin
              prev_freq_next = item.frequency;
              save           = stable;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (save) begin
      push.count                 = 2'd2;
      push.first.kind            = K_SAVE;
      push.first.table_code      = tcode;
      push.first.saved_frequency = item.frequency;
      push.second.last           = 1'b1;
      if (code == CODE_TOP) begin
        busy_next        = 1'b0;
        push.second.kind = K_DONE;
      end else begin
        code_next              = code_inc;
        count_next             = '0;
        push.second.kind       = K_SET;
        push.second.dac_code   = DAC_OUT_W'(code_inc);
        push.second.half_range = half;
      end
    end

    if (!fire) begin
      push.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_limit <= READ_LIMIT_RST;
      tol_div    <= TOL_DIV_RST;
      busy       <= 1'b0;
      code       <= '0;
      prev_freq  <= '0;
      count      <= '0;
      half       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_READ_LIMIT: read_limit <= cfg_data[LIMIT_W-1:0];
          REG_TOL_DIV:    tol_div    <= cfg_data[TOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        busy      <= busy_next;
        code      <= code_next;
        prev_freq <= prev_freq_next;
        count     <= count_next;
        half      <= half_next;
      end
    end
  end

endmodule

// ===== rtl/core/dfcs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcs_fifo
// Four-entry result queue: takes up to two items a cycle, gives out one.
// ----------------------------------------------------------------------------
module dfcs_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  dfcs_pkg::dfcs_push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dfcs_pkg::dfcs_out_t  out_item
);
  import dfcs_pkg::*;

  dfcs_out_t   mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill, fill_next;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign out_item  = mem[rd_ptr];
  // two free slots needed before an item may be processed
  assign room      = fill <= 3'd2;
  assign fill_next = fill + 3'(push.count) - 3'(pop);

  always_ff @(posedge clk) begin
    if (push.count != '0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      fill   <= fill_next;
    end
  end

endmodule

// ===== tb/sv/dfcs_sweep_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcs_sweep_checker
// Watches the item channels and register port of the calibration sweep unit,
// predicts the commands each accepted item produces and compares them in order.
// ----------------------------------------------------------------------------
module dfcs_sweep_checker
  import dfcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  dfcs_in_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  dfcs_out_t            out_item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int SHOWN_MAX = 60;

  // register copies
  logic [LIMIT_W-1:0]  read_limit;
  logic [TOL_W-1:0]    tol_div;

  // sweep state
  logic                sweeping;
  logic [DAC_BITS-1:0] code;
  logic [FREQ_W-1:0]   prev_freq;
  logic [LIMIT_W-1:0]  reads;
  logic                half_sel;

  dfcs_out_t commands_due[$];
  int        fails  = 0;
  int        queued = 0;

  assign mismatches  = fails;
  assign outstanding = queued;

  task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] got,
                                 input logic [FREQ_W-1:0] want);
    fails++;
    if (fails <= SHOWN_MAX) begin
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  function automatic dfcs_out_t blank_command(input logic [KIND_W-1:0] kind);
    dfcs_out_t c;
    c      = '0;
    c.kind = kind;
    return c;
  endfunction

  task automatic predict_commands(input dfcs_in_t item);
    dfcs_out_t          cmds[2];
    int                 n;
    logic [LIMIT_W:0]   next_reads;
    logic [FREQ_W-1:0]  diff;
    logic [PROD_W-1:0]  scaled;
    logic               keep;
    n    = 0;
    keep = 1'b0;
    case (item.operation)
      OP_START: if (!sweeping) begin
        sweeping  = 1'b1;
        half_sel  = item.half_mode;
        code      = '0;
        prev_freq = '0;
        reads     = '0;
        cmds[0]   = blank_command(K_RESET);
        cmds[1]   = blank_command(K_SET);
        cmds[1].half_range = half_sel;
        n = 2;
      end
      OP_ABORT: if (sweeping) begin
        sweeping        = 1'b0;
        cmds[0]         = blank_command(K_DONE);
        cmds[0].aborted = 1'b1;
        n = 1;
      end
      OP_MEASURE: if (sweeping) begin
        if (reads == '0) begin
          prev_freq = item.frequency;
          reads     = LIMIT_W'(1);
        end else begin
          next_reads = reads + 1'b1;
          reads = (next_reads > COUNT_MAX) ? COUNT_MAX : next_reads[LIMIT_W-1:0];
          if (next_reads > read_limit) begin
            keep = 1'b1;
          end else if (item.frequency != '0 && prev_freq == '0) begin
            prev_freq = item.frequency;
          end else if (item.frequency == '0) begin
            keep = 1'b1;
          end else begin
            diff = (item.frequency >= prev_freq) ? item.frequency - prev_freq
                                                 : prev_freq - item.frequency;
            prev_freq = item.frequency;
            scaled    = PROD_W'(diff) * PROD_W'(tol_div);
            keep      = (scaled <= PROD_W'(item.frequency));
          end
        end
        if (keep) begin
          cmds[0] = blank_command(K_SAVE);
          cmds[0].table_code      = TCODE_W'(code) + (half_sel ? HALF_OFFSET : '0);
          cmds[0].saved_frequency = item.frequency;
          if (code == CODE_TOP) begin
            sweeping = 1'b0;
            cmds[1]  = blank_command(K_DONE);
          end else begin
            code    = code + 1'b1;
            reads   = '0;
            cmds[1] = blank_command(K_SET);
            cmds[1].dac_code   = DAC_OUT_W'(code);
            cmds[1].half_range = half_sel;
          end
          n = 2;
        end
      end
      default: ;
    endcase
    if (n > 0) cmds[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) commands_due.push_back(cmds[i]);
  endtask

  task automatic check_command(input dfcs_out_t got);
    dfcs_out_t want;
    if (commands_due.size() == 0) begin
      report_mismatch("unrequested command, kind", got.kind, '0);
    end else begin
      want = commands_due.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.dac_code != want.dac_code)
        report_mismatch("dac_code", got.dac_code, want.dac_code);
      if (got.half_range != want.half_range)
        report_mismatch("half_range", got.half_range, want.half_range);
      if (got.table_code != want.table_code)
        report_mismatch("table_code", got.table_code, want.table_code);
      if (got.saved_frequency != want.saved_frequency)
        report_mismatch("saved_frequency", got.saved_frequency, want.saved_frequency);
      if (got.aborted != want.aborted)
        report_mismatch("aborted", got.aborted, want.aborted);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      read_limit = READ_LIMIT_RST;
      tol_div    = TOL_DIV_RST;
      sweeping   = 1'b0;
      code       = '0;
      prev_freq  = '0;
      reads      = '0;
      half_sel   = 1'b0;
      commands_due.delete();
    end else begin
      if (out_valid && out_ready) check_command(out_item);
      if (in_valid && in_ready) predict_commands(in_item);
      if (cfg_write) begin
        case (cfg_index)
          REG_READ_LIMIT: read_limit = cfg_data[LIMIT_W-1:0];
          REG_TOL_DIV:    tol_div    = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
    end
    queued = commands_due.size();
  end

endmodule

// ===== tb/sv/dac_frequency_calibration_sweep_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_frequency_calibration_sweep_unit_tb
// Drives start, abort and measurement items into the sweep unit under random
// back-pressure on both sides, across several register settings. A checker
// beside the block predicts and compares every command; this module only
// makes stimulus and gives verdict.
// ----------------------------------------------------------------------------
module dac_frequency_calibration_sweep_unit_tb;
  import dfcs_pkg::*;

  localparam int HALF_PERIOD  = 4;
  // an item with no command may still sit in the input register once the
  // last expected command has left
  localparam int QUIET_CYCLES = 8;
  localparam int STALL_LIMIT  = 200;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 6;

  // operation value the block does not define; it must be dropped
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  dfcs_in_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dfcs_out_t            out_item;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int                   mismatches;
  int                   outstanding;
  int                   stalled   = 0;
  // rough idea of whether a sweep is running, used only to shape stimulus
  bit                   in_sweep  = 1'b0;
  logic [FREQ_W-1:0]    last_freq = '0;

  // register settings per random phase: extremes first, then ordinary ones
  logic [LIMIT_W-1:0] limits[PHASES] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd7, 4'd10};
  logic [TOL_W-1:0]   tols[PHASES]   = '{10'd0, 10'd1023, 10'd1, 10'd100, 10'd2, 10'd100};

  dac_frequency_calibration_sweep_unit dut (
    .clk, .rst,
    .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item,
    .cfg_write, .cfg_index, .cfg_data
  );

  dfcs_sweep_checker u_sweep_check (
    .clk, .rst,
    .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item,
    .cfg_write, .cfg_index, .cfg_data,
    .mismatches, .outstanding
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  function automatic int draw_gap();
    return $urandom_range(0, 9);
  endfunction

  function automatic dfcs_in_t make_item(input logic [OP_W-1:0] op, input logic half,
                                         input logic [FREQ_W-1:0] freq);
    dfcs_in_t item;
    item.operation = op;
    item.half_mode = half;
    item.frequency = freq;
    return item;
  endfunction

  // Receiver: for each command draw a stall, then hold ready until one is taken.
  // Ready is only lowered when a stall is drawn, so it never toggles in one step.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one item after a random gap and hold it until accepted. Returns at
  // the falling edge after acceptance with valid still high; the caller either
  // sends again or drops valid through settle.
  task automatic send(input dfcs_in_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item  <= make_item(OP_W'($urandom), 1'($urandom), $urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected command, then let the block drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly near the last reading so stable and unstable cases both occur,
  // with some zeros, tiny values and full-range noise mixed in.
  function automatic logic [FREQ_W-1:0] next_reading();
    logic [FREQ_W-1:0] jitter;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 20) return $urandom;
    if (pick < 30) return $urandom_range(1, 50);
    jitter = last_freq >> $urandom_range(3, 12);
    if ($urandom_range(0, 1)) return last_freq + $urandom_range(0, jitter);
    return last_freq - $urandom_range(0, jitter);
  endfunction

  // Random items shaped into sweeps: while idle mostly starts, while running
  // mostly measurements, with stray starts, aborts and unused operations.
  task automatic random_items(input int count);
    int                sent;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [FREQ_W-1:0] freq;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (!in_sweep) begin
        op = (pick < 80) ? OP_START : (pick < 88) ? OP_MEASURE :
             (pick < 94) ? OP_ABORT : OP_UNUSED;
      end else begin
        op = (pick < 3) ? OP_START : (pick < 6) ? OP_ABORT :
             (pick < 9) ? OP_UNUSED : OP_MEASURE;
      end
      freq = $urandom;
      if (op == OP_MEASURE) begin
        freq = next_reading();
        last_freq = freq;
      end
      sent++;
      if (op == OP_START) begin
        if (!in_sweep) last_freq = $urandom >> $urandom_range(0, 24);
        in_sweep = 1'b1;
      end
      if (op == OP_ABORT) in_sweep = 1'b0;
      send(make_item(op, 1'($urandom), freq));
    end
  endtask

  initial begin
    logic [CFG_W-LIMIT_W-1:0] spare;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on reset register values (limit 10, divisor 100).
    // Idle: measurement, abort and the unused operation are all dropped.
    send(make_item(OP_MEASURE, 1'b1, 32'hFFFF_FFFF));
    send(make_item(OP_ABORT, 1'b1, '0));
    send(make_item(OP_UNUSED, 1'b0, 32'h5A5A_A5A5));
    // Start in half range; a second start while running is dropped.
    send(make_item(OP_START, 1'b1, '0));
    send(make_item(OP_START, 1'b0, '0));
    // Zero primes, a zero reading then saves at once.
    send(make_item(OP_MEASURE, 1'b0, '0));
    send(make_item(OP_MEASURE, 1'b0, '0));
    // Change within tolerance saves.
    send(make_item(OP_MEASURE, 1'b0, 32'd1000));
    send(make_item(OP_MEASURE, 1'b0, 32'd1005));
    // Large changes replace the previous reading until one settles.
    send(make_item(OP_MEASURE, 1'b0, 32'd5));
    send(make_item(OP_MEASURE, 1'b0, 32'd50));
    send(make_item(OP_MEASURE, 1'b0, 32'h8000_0000));
    send(make_item(OP_MEASURE, 1'b0, 32'h8000_0001));
    send(make_item(OP_UNUSED, 1'b1, '0));
    // Full-scale readings with no change.
    send(make_item(OP_MEASURE, 1'b1, 32'hFFFF_FFFF));
    send(make_item(OP_MEASURE, 1'b1, 32'hFFFF_FFFF));
    send(make_item(OP_ABORT, 1'b0, '0));
    // Full range this time; a nonzero reading after a zero one only replaces it.
    send(make_item(OP_START, 1'b0, '0));
    send(make_item(OP_MEASURE, 1'b0, '0));
    send(make_item(OP_MEASURE, 1'b0, 32'd7));
    send(make_item(OP_MEASURE, 1'b0, 32'd7));
    send(make_item(OP_ABORT, 1'b1, '0));
    settle();

    // Random phases, one per register setting. Spare data bits above the
    // read limit are filled at random; the block must ignore them.
    for (int p = 0; p < PHASES; p++) begin
      spare = (CFG_W-LIMIT_W)'($urandom);
      write_reg(REG_READ_LIMIT, {spare, limits[p]});
      write_reg(REG_TOL_DIV, tols[p]);
      random_items(RANDOM_ITEMS / PHASES);
      settle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== dac_frequency_calibration_sweep_unit.f =====
rtl/core/dfcs_pkg.sv
rtl/core/dfcs_core.sv
rtl/core/dfcs_fifo.sv
rtl/core/dac_frequency_calibration_sweep_unit.sv
tb/sv/dfcs_sweep_checker.sv
tb/sv/dac_frequency_calibration_sweep_unit_tb.sv
